>>> sv/vpp_pkg.sv
// Shared widths and types for the vector plane projection pipeline.
package vpp_pkg;

   localparam int QW      = 16;        // Q8.8 component width
   localparam int PROD_W  = 2 * QW;    // one 16x16 product
   localparam int DOT_W   = PROD_W + 2; // sum of three signed products
   localparam int NN_W    = PROD_W;    // sum of three squares, unsigned
   localparam int NVN_W   = QW + DOT_W; // normal component times v.n
   localparam int NUM_W   = NVN_W;     // 2*|n_i*(v.n)| + n.n
   localparam int DEN_W   = NN_W + 1;  // 2*(n.n)
   localparam int QUOT_W  = QW + 1;    // rounded correction magnitude
   localparam int DIFF_W  = QW + 3;    // v_i minus signed correction

   localparam int REQ_W   = 6 * QW;
   localparam int RSP_W   = 3 * QW;

   localparam logic signed [DIFF_W-1:0] Q_MAX = DIFF_W'(32767);
   localparam logic signed [DIFF_W-1:0] Q_MIN = -DIFF_W'(32768);

   typedef logic signed [QW-1:0] comp_type;
   typedef comp_type vec3_type [3];

endpackage

>>> sv/vpp_divider.sv
// Pipelined restoring divider, one quotient bit per stage, for one lane.
module vpp_divider (
   input  logic                         clock,
   input  logic                         en,
   input  logic [vpp_pkg::NUM_W-1:0]    num,
   input  logic [vpp_pkg::DEN_W-1:0]    den,
   output logic [vpp_pkg::QUOT_W-1:0]   quot
);
   import vpp_pkg::*;

   logic [NUM_W-1:0]  rem_ff  [QUOT_W-1];
   logic [DEN_W-1:0]  den_ff  [QUOT_W-1];
   logic [QUOT_W-1:0] quot_ff [QUOT_W];

   genvar k;
   generate
      for (k = 0; k < QUOT_W; k++) begin : g_step
         logic [NUM_W-1:0]  rem_cur;
         logic [NUM_W-1:0]  sub_val;
         logic [DEN_W-1:0]  den_cur;
         logic [QUOT_W-1:0] quot_cur;
         logic [QUOT_W-1:0] quot_in;
         logic              ge;

         if (k == 0) begin : g_first
            assign rem_cur  = num;
            assign den_cur  = den;
            assign quot_cur = '0;
         end else begin : g_next
            assign rem_cur  = rem_ff[k-1];
            assign den_cur  = den_ff[k-1];
            assign quot_cur = quot_ff[k-1];
         end

         // Trial subtract of the divisor aligned to this quotient bit.
         assign sub_val = NUM_W'(den_cur) << (QUOT_W - 1 - k);
         assign ge      = (rem_cur >= sub_val);
         assign quot_in = quot_cur | (QUOT_W'(ge) << (QUOT_W - 1 - k));

         always_ff @(posedge clock) begin
            if (en) begin
               quot_ff[k] <= quot_in;
            end
         end

         if (k < QUOT_W - 1) begin : g_rem
            logic [NUM_W-1:0] rem_in;
            assign rem_in = ge ? (rem_cur - sub_val) : rem_cur;
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[k] <= rem_in;
                  den_ff[k] <= den_cur;
               end
            end
         end
      end
   endgenerate

   assign quot = quot_ff[QUOT_W-1];

endmodule

>>> sv/vector_plane_projection.sv
// Projects a Q8.8 3D vector onto the plane given by a normal of any length.
// Throughput: one transaction per cycle; the whole pipeline advances together
// and holds while a finished result waits on rsp_tready.
// The 17-stage divider (one quotient bit per stage) sets the depth.
// Reset (synchronous, active high) clears all valid bits; data is not reset.
module vector_plane_projection (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // vec_x, vec_y, vec_z, norm_x, norm_y, norm_z, 16 bits each
   input  logic [vpp_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // proj_x, proj_y, proj_z, 16 bits each
   output logic [vpp_pkg::RSP_W-1:0]  rsp_tdata,
   // zero_normal
   output logic                       rsp_tuser
);
   import vpp_pkg::*;

   localparam int DIV_D = QUOT_W;

   // Global advance: every stage moves when the output register is free.
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // Unpack the input transaction.
   vec3_type v_in, n_in;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v_in[i] = comp_type'(req_tdata[i*QW +: QW]);
         n_in[i] = comp_type'(req_tdata[(i+3)*QW +: QW]);
      end
   end

   // Stage 1: the six component products.
   logic                      s1_valid_ff;
   vec3_type                  s1_v_ff, s1_n_ff;
   logic signed [PROD_W-1:0]  s1_vn_ff [3];
   logic signed [PROD_W-1:0]  s1_nn_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_v_ff[i]  <= v_in[i];
            s1_n_ff[i]  <= n_in[i];
            s1_vn_ff[i] <= v_in[i] * n_in[i];
            s1_nn_ff[i] <= n_in[i] * n_in[i];
         end
      end
   end

   // Stage 2: v.n and n.n, both exact.
   logic                     s2_valid_ff;
   vec3_type                 s2_v_ff, s2_n_ff;
   logic signed [DOT_W-1:0]  s2_dot_ff;
   logic [NN_W-1:0]          s2_nn_ff;
   logic signed [DOT_W-1:0]  dot_in;
   logic [NN_W-1:0]          nn_in;

   assign dot_in = DOT_W'(s1_vn_ff[0]) + DOT_W'(s1_vn_ff[1]) + DOT_W'(s1_vn_ff[2]);
   // Squares are never negative and their sum stays below 2^32.
   assign nn_in  = NN_W'(s1_nn_ff[0]) + NN_W'(s1_nn_ff[1]) + NN_W'(s1_nn_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_v_ff   <= s1_v_ff;
         s2_n_ff   <= s1_n_ff;
         s2_dot_ff <= dot_in;
         s2_nn_ff  <= nn_in;
      end
   end

   // Stage 3: numerators n_i * (v.n).
   logic                     s3_valid_ff;
   vec3_type                 s3_v_ff;
   logic signed [NVN_W-1:0]  s3_nvn_ff [3];
   logic [NN_W-1:0]          s3_nn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_v_ff  <= s2_v_ff;
         s3_nn_ff <= s2_nn_ff;
         for (int i = 0; i < 3; i++) begin
            s3_nvn_ff[i] <= NVN_W'(s2_n_ff[i]) * NVN_W'(s2_dot_ff);
         end
      end
   end

   // Stage 4: round-to-nearest operands. floor((2|a| + d) / 2d) rounds
   // the magnitude with ties away from zero; the sign is reapplied later.
   logic                s4_valid_ff;
   vec3_type            s4_v_ff;
   logic [NUM_W-1:0]    s4_num_ff [3];
   logic [DEN_W-1:0]    s4_den_ff;
   logic [2:0]          s4_neg_ff;
   logic                s4_zero_ff;
   logic [NUM_W-1:0]    num_in [3];
   logic [2:0]          neg_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [NVN_W-1:0] mag;
         neg_in[i] = s3_nvn_ff[i][NVN_W-1];
         mag       = neg_in[i] ? NVN_W'(-s3_nvn_ff[i]) : NVN_W'(s3_nvn_ff[i]);
         num_in[i] = NUM_W'({mag[NVN_W-2:0], 1'b0}) + NUM_W'(s3_nn_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_v_ff    <= s3_v_ff;
         s4_num_ff  <= num_in;
         s4_den_ff  <= {s3_nn_ff, 1'b0};
         s4_neg_ff  <= neg_in;
         s4_zero_ff <= (s3_nn_ff == '0);
      end
   end

   // Divider lanes; a zero normal makes their result meaningless, which
   // the carried flag covers at the output.
   logic [QUOT_W-1:0] quot [3];

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_lane
         vpp_divider u_div (
            .clock (clock),
            .en    (en),
            .num   (s4_num_ff[g]),
            .den   (s4_den_ff),
            .quot  (quot[g])
         );
      end
   endgenerate

   // Side data travels alongside the divider stages.
   logic       dl_valid_ff [DIV_D];
   vec3_type   dl_v_ff     [DIV_D];
   logic [2:0] dl_neg_ff   [DIV_D];
   logic       dl_zero_ff  [DIV_D];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_D; k++) begin
            dl_valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         dl_valid_ff[0] <= s4_valid_ff;
         for (int k = 1; k < DIV_D; k++) begin
            dl_valid_ff[k] <= dl_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dl_v_ff[0]    <= s4_v_ff;
         dl_neg_ff[0]  <= s4_neg_ff;
         dl_zero_ff[0] <= s4_zero_ff;
         for (int k = 1; k < DIV_D; k++) begin
            dl_v_ff[k]    <= dl_v_ff[k-1];
            dl_neg_ff[k]  <= dl_neg_ff[k-1];
            dl_zero_ff[k] <= dl_zero_ff[k-1];
         end
      end
   end

   // Output stage: subtract the signed correction (none for a zero normal) and saturate to Q8.8.
   logic                 out_valid_ff;
   logic [RSP_W-1:0]     out_data_ff;
   logic                 out_zero_ff;
   logic [RSP_W-1:0]     out_data_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [DIFF_W-1:0] corr;
         logic signed [DIFF_W-1:0] diff;
         logic signed [DIFF_W-1:0] vext;
         vext = DIFF_W'(dl_v_ff[DIV_D-1][i]);
         corr = dl_neg_ff[DIV_D-1][i] ? -DIFF_W'(quot[i]) : DIFF_W'(quot[i]);
         diff = dl_zero_ff[DIV_D-1] ? vext : (vext - corr);
         if (diff > Q_MAX) begin
            out_data_in[i*QW +: QW] = QW'(Q_MAX);
         end else if (diff < Q_MIN) begin
            out_data_in[i*QW +: QW] = QW'(Q_MIN);
         end else begin
            out_data_in[i*QW +: QW] = QW'(diff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dl_valid_ff[DIV_D-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= out_data_in;
         out_zero_ff <= dl_zero_ff[DIV_D-1];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_zero_ff;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the vector plane projection pipeline.
`timescale 1ns / 100ps

module tb_top;
   import vpp_pkg::*;

   localparam int NUM_RANDOM   = 1350;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 2000;

   // One row of the directed table: the operands and, where the answer is
   // obvious, the expected projection typed in by hand.
   typedef struct {
      logic signed [15:0] vec [3];
      logic signed [15:0] nrm [3];
      logic               typed;
      logic signed [15:0] proj [3];
      logic               zero_nrm;
   } stim_row_type;

   typedef struct packed {
      logic [RSP_W-1:0] data;
      logic             zero_nrm;
   } projection_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;    // vec_x, vec_y, vec_z, norm_x, norm_y, norm_z
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;    // proj_x, proj_y, proj_z
   logic             rsp_tuser;    // zero_normal

   projection_type expected_projections [$];
   int             error_count;
   int             idle_cycles;
   logic           stimulus_done;

   vector_plane_projection u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Rounds num/den to nearest with ties away from zero; den is positive.
   function automatic longint round_quotient(input longint num, input longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return (num < 0) ? -q : q;
   endfunction

   function automatic logic [15:0] saturate_q88(input longint x);
      if (x < -32768) return 16'h8000;
      if (x > 32767) return 16'h7fff;
      return x[15:0];
   endfunction

   // Removes the component along the normal: v - n (v.n) / (n.n).
   function automatic projection_type project_onto_plane(input logic [REQ_W-1:0] item);
      longint         v [3];
      longint         n [3];
      longint         vdot;
      longint         ndot;
      projection_type res;
      vdot = 0;
      ndot = 0;
      for (int i = 0; i < 3; i++) begin
         v[i] = longint'($signed(item[16*i +: 16]));
         n[i] = longint'($signed(item[16*(i+3) +: 16]));
      end
      for (int i = 0; i < 3; i++) begin
         vdot += v[i] * n[i];
         ndot += n[i] * n[i];
      end
      res.zero_nrm = (ndot == 0);
      for (int i = 0; i < 3; i++) begin
         if (ndot == 0) begin
            res.data[16*i +: 16] = v[i][15:0];
         end else begin
            res.data[16*i +: 16] = saturate_q88(v[i] - round_quotient(n[i] * vdot, ndot));
         end
      end
      return res;
   endfunction

   // Sends one transaction after a random gap and records what must come back.
   // The valid line drops only during a gap, so back-to-back transactions keep it high.
   task automatic send_vector(input logic [REQ_W-1:0] item, input logic typed,
                              input projection_type typed_res);
      projection_type predicted;
      int             gap;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = project_onto_plane(item);
      if (typed && predicted != typed_res) begin
         $display("%0t: typed row disagrees with prediction: exp %h act %h",
                  $time, typed_res, predicted);
         error_count++;
      end
      expected_projections.push_back(typed ? typed_res : predicted);
   endtask

   function automatic logic [REQ_W-1:0] pack_row(input stim_row_type r);
      return {r.nrm[2], r.nrm[1], r.nrm[0], r.vec[2], r.vec[1], r.vec[0]};
   endfunction

   function automatic logic signed [15:0] random_component();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($signed($urandom_range(0, 1023)) - 512);
         3: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Stimulus: directed table, then random vectors with a sender pause.
   initial begin
      stim_row_type   directed [$];
      stim_row_type   r;
      projection_type tr;
      logic [REQ_W-1:0] item;

      req_tvalid    = 1'b0;
      req_tdata     = '0;
      reset         = 1'b1;
      error_count   = 0;
      stimulus_done = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Zero normal passes the vector through, including the extremes.
      r = '{vec:'{16'sh0100, -16'sh0200, 16'sh0300}, nrm:'{0, 0, 0}, typed:1,
            proj:'{16'sh0100, -16'sh0200, 16'sh0300}, zero_nrm:1};
      directed.push_back(r);
      r = '{vec:'{16'sh7fff, 16'sh8000, 16'sh7fff}, nrm:'{0, 0, 0}, typed:1,
            proj:'{16'sh7fff, 16'sh8000, 16'sh7fff}, zero_nrm:1};
      directed.push_back(r);
      // A normal along one axis removes that component exactly.
      r = '{vec:'{16'sh0100, 16'sh0200, 16'sh0300}, nrm:'{0, 0, 16'sh0100}, typed:1,
            proj:'{16'sh0100, 16'sh0200, 0}, zero_nrm:0};
      directed.push_back(r);
      r = '{vec:'{16'sh7fff, 16'sh8000, 16'sh8000}, nrm:'{16'sh8000, 0, 0}, typed:1,
            proj:'{0, 16'sh8000, 16'sh8000}, zero_nrm:0};
      directed.push_back(r);
      // Out-of-range results that saturate, and rounding ties.
      r = '{vec:'{16'sh7fff, 16'sh8000, 0}, nrm:'{16'sh0001, 16'sh0001, 0}, typed:0,
            proj:'{0, 0, 0}, zero_nrm:0};
      directed.push_back(r);
      r = '{vec:'{16'sh8000, 16'sh7fff, 0}, nrm:'{16'sh0001, 16'sh0001, 0}, typed:0,
            proj:'{0, 0, 0}, zero_nrm:0};
      directed.push_back(r);
      r = '{vec:'{16'sh0001, 0, 0}, nrm:'{16'sh0001, 16'sh0001, 0}, typed:0,
            proj:'{0, 0, 0}, zero_nrm:0};
      directed.push_back(r);
      r = '{vec:'{-16'sh0001, 0, 0}, nrm:'{16'sh0001, 16'sh0001, 0}, typed:0,
            proj:'{0, 0, 0}, zero_nrm:0};
      directed.push_back(r);
      r = '{vec:'{16'sh8000, 16'sh8000, 16'sh8000}, nrm:'{16'sh8000, 16'sh8000, 16'sh8000},
            typed:0, proj:'{0, 0, 0}, zero_nrm:0};
      directed.push_back(r);
      r = '{vec:'{16'sh7fff, 16'sh7fff, 16'sh7fff}, nrm:'{16'sh8000, 16'sh7fff, 16'sh0001},
            typed:0, proj:'{0, 0, 0}, zero_nrm:0};
      directed.push_back(r);
      r = '{vec:'{16'sh1234, -16'sh4321, 16'sh0777}, nrm:'{16'sh0003, -16'sh0005, 16'sh0007},
            typed:0, proj:'{0, 0, 0}, zero_nrm:0};
      directed.push_back(r);

      foreach (directed[k]) begin
         tr.data     = {directed[k].proj[2], directed[k].proj[1], directed[k].proj[0]};
         tr.zero_nrm = directed[k].zero_nrm;
         send_vector(pack_row(directed[k]), directed[k].typed, tr);
      end

      for (int k = 0; k < NUM_RANDOM; k++) begin
         // Partway through, the sender waits until the pipeline has drained.
         if (k == NUM_RANDOM / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (expected_projections.size() != 0) @(posedge clock);
         end
         for (int i = 0; i < 6; i++) begin
            item[16*i +: 16] = random_component();
         end
         if ($urandom_range(0, 19) == 0) item[REQ_W-1 -: 48] = '0;
         send_vector(item, 1'b0, tr);
      end
      req_tvalid    <= 1'b0;
      stimulus_done <= 1'b1;
   end

   // Receiver back-pressure: random stalls plus one long hold early on.
   initial begin
      int hold;
      rsp_tready = 1'b0;
      @(negedge reset);
      @(posedge clock);
      repeat (200) begin
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
      rsp_tready <= 1'b0;
      repeat (120) @(posedge clock);
      forever begin
         if ($urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end else begin
            hold = $urandom_range(0, 5);
            if (hold != 0) begin
               rsp_tready <= 1'b0;
               repeat (hold) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compares each accepted result with the oldest expected projection.
   always @(posedge clock) begin
      projection_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_projections.size() == 0) begin
            $display("%0t: unexpected result: exp none act %h/%b",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = expected_projections.pop_front();
            for (int i = 0; i < 3; i++) begin
               if (rsp_tdata[16*i +: 16] !== want.data[16*i +: 16]) begin
                  $display("%0t: proj component %0d mismatch: exp %h act %h",
                           $time, i, want.data[16*i +: 16], rsp_tdata[16*i +: 16]);
                  error_count++;
               end
            end
            if (rsp_tuser !== want.zero_nrm) begin
               $display("%0t: zero_normal mismatch: exp %b act %b",
                        $time, want.zero_nrm, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted transaction, and end of run.
   initial begin
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
         if (stimulus_done && expected_projections.size() == 0) begin
            break;
         end
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_projections.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> vector_plane_projection.f
sv/vpp_pkg.sv
sv/vpp_divider.sv
sv/vector_plane_projection.sv
test/tb_top.sv
